[rtl/jgs_pkg.sv]
package jgs_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_SLOT0    = 3'd0,
		REG_SLOT1    = 3'd1,
		REG_SLOT2    = 3'd2,
		REG_SLOT3    = 3'd3,
		REG_PRESENT  = 3'd4,
		REG_LEFT_DZ  = 3'd5,
		REG_RIGHT_DZ = 3'd6,
		REG_TRIG_THR = 3'd7
	} reg_index_t;

	// Reset values of the configuration registers.
	localparam logic [15:0] LEFT_DZ_RESET  = 16'd7849;
	localparam logic [15:0] RIGHT_DZ_RESET = 16'd8689;
	localparam logic [7:0]  TRIG_THR_RESET = 8'd30;

	// User slot code that stands for any slot; the map treats it as slot 0.
	localparam logic [7:0] USER_ANY = 8'hFF;

	// Hat octant edges in hundredths of a degree (multiples of 4500).
	localparam logic [15:0] HAT_OCT1 = 16'd4500;
	localparam logic [15:0] HAT_OCT2 = 16'd9000;
	localparam logic [15:0] HAT_OCT3 = 16'd13500;
	localparam logic [15:0] HAT_OCT4 = 16'd18000;
	localparam logic [15:0] HAT_OCT5 = 16'd22500;
	localparam logic [15:0] HAT_OCT6 = 16'd27000;
	localparam logic [15:0] HAT_OCT7 = 16'd31500;
	localparam logic [15:0] HAT_OCT8 = 16'd36000;

	// Trigger scaling: full-scale positive range.
	localparam logic [15:0] TRIG_RANGE_POS = 16'd32767;

	// Pad button bits.
	localparam logic [15:0] PAD_UP     = 16'h0001;
	localparam logic [15:0] PAD_DOWN   = 16'h0002;
	localparam logic [15:0] PAD_LEFT   = 16'h0004;
	localparam logic [15:0] PAD_RIGHT  = 16'h0008;
	localparam logic [15:0] PAD_START  = 16'h0010;
	localparam logic [15:0] PAD_BACK   = 16'h0020;
	localparam logic [15:0] PAD_LTHUMB = 16'h0040;
	localparam logic [15:0] PAD_RTHUMB = 16'h0080;
	localparam logic [15:0] PAD_LSHLD  = 16'h0100;
	localparam logic [15:0] PAD_RSHLD  = 16'h0200;
	localparam logic [15:0] PAD_A      = 16'h1000;
	localparam logic [15:0] PAD_B      = 16'h2000;
	localparam logic [15:0] PAD_X      = 16'h4000;
	localparam logic [15:0] PAD_Y      = 16'h8000;

	typedef struct packed {
		logic [4:0]  slot0;
		logic [4:0]  slot1;
		logic [4:0]  slot2;
		logic [4:0]  slot3;
		logic        present;
		logic [15:0] left_dz;
		logic [15:0] right_dz;
		logic [7:0]  trig_thr;
	} cfg_t;

	typedef struct packed {
		logic [7:0]         user_index;
		logic [9:0]         raw_buttons;
		logic [15:0]        hat_angle;
		logic signed [15:0] axis_left_x;
		logic signed [15:0] axis_left_y;
		logic signed [15:0] axis_right_x;
		logic signed [15:0] axis_right_y;
		logic signed [15:0] axis_trigger;
	} poll_t;

	typedef struct packed {
		logic               status;
		logic [3:0]         target_controller;
		logic [15:0]        pad_buttons;
		logic signed [15:0] thumb_left_x;
		logic signed [15:0] thumb_left_y;
		logic signed [15:0] thumb_right_x;
		logic signed [15:0] thumb_right_y;
		logic [7:0]         trigger_left;
		logic [7:0]         trigger_right;
		logic [31:0]        packet_number;
	} pad_rec_t;

endpackage

[rtl/joystick_to_gamepad_state.sv]
// Channel  Direction  Transfer payload
// s_*      in         joystick poll: tuser = user_index, tdata = buttons, hat, axes
// m_*      out        gamepad record: tuser = status, tdata = record fields
// wr_*     in         configuration write, one register per cycle
//
// One poll per cycle is sustained while m_tready stays high; a poll passes the
// input register then the result register, with the conversion between them.
// Reset clears both stage valids and the packet counter and sets the
// configuration registers to their reset values. A stalled output holds its
// result; an empty input register can still take one poll, after which
// s_tready follows m_tready.
module joystick_to_gamepad_state (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [9:0] raw_buttons, [25:10] hat_angle, [41:26] axis_left_x,
	// [57:42] axis_left_y, [73:58] axis_right_x, [89:74] axis_right_y,
	// [105:90] axis_trigger, [111:106] zero
	input  logic [111:0] s_tdata,
	// [7:0] user_index
	input  logic [7:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [3:0] target_controller, [19:4] pad_buttons, [35:20] thumb_left_x,
	// [51:36] thumb_left_y, [67:52] thumb_right_x, [83:68] thumb_right_y,
	// [91:84] trigger_left, [99:92] trigger_right, [131:100] packet_number,
	// [135:132] zero
	output logic [135:0] m_tdata,
	// [0] status
	output logic         m_tuser,
	input  logic         wr_en,
	input  logic [2:0]   wr_index,
	input  logic [15:0]  wr_data
);
	import jgs_pkg::*;

	cfg_t     cfg_q;
	logic     v_s1;
	poll_t    poll_s1;
	logic     v_s2;
	pad_rec_t rec_s2;
	pad_rec_t rec;
	logic [31:0] cnt_q;
	logic     adv;
	logic     take;

	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;
	assign take     = s_tvalid && s_tready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot0    <= 5'd0;
			cfg_q.slot1    <= 5'd0;
			cfg_q.slot2    <= 5'd0;
			cfg_q.slot3    <= 5'd0;
			cfg_q.present  <= 1'b0;
			cfg_q.left_dz  <= LEFT_DZ_RESET;
			cfg_q.right_dz <= RIGHT_DZ_RESET;
			cfg_q.trig_thr <= TRIG_THR_RESET;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_SLOT0:    cfg_q.slot0    <= wr_data[4:0];
				REG_SLOT1:    cfg_q.slot1    <= wr_data[4:0];
				REG_SLOT2:    cfg_q.slot2    <= wr_data[4:0];
				REG_SLOT3:    cfg_q.slot3    <= wr_data[4:0];
				REG_PRESENT:  cfg_q.present  <= wr_data[0];
				REG_LEFT_DZ:  cfg_q.left_dz  <= wr_data;
				REG_RIGHT_DZ: cfg_q.right_dz <= wr_data;
				REG_TRIG_THR: cfg_q.trig_thr <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage valids and the packet counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			cnt_q <= 32'd0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
				if (!rec.status) begin
					cnt_q <= cnt_q + 32'd1;
				end
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take) begin
			poll_s1.user_index   <= s_tuser;
			poll_s1.raw_buttons  <= s_tdata[9:0];
			poll_s1.hat_angle    <= s_tdata[25:10];
			poll_s1.axis_left_x  <= s_tdata[41:26];
			poll_s1.axis_left_y  <= s_tdata[57:42];
			poll_s1.axis_right_x <= s_tdata[73:58];
			poll_s1.axis_right_y <= s_tdata[89:74];
			poll_s1.axis_trigger <= s_tdata[105:90];
		end
		if (adv) begin
			rec_s2 <= rec;
		end
	end

	jgs_map u_map (
		.cfg   (cfg_q),
		.poll  (poll_s1),
		.count (cnt_q),
		.rec   (rec)
	);

	assign m_tvalid = v_s2;
	assign m_tuser  = rec_s2.status;
	assign m_tdata  = {4'd0, rec_s2.packet_number, rec_s2.trigger_right,
		rec_s2.trigger_left, rec_s2.thumb_right_y, rec_s2.thumb_right_x,
		rec_s2.thumb_left_y, rec_s2.thumb_left_x, rec_s2.pad_buttons,
		rec_s2.target_controller};

endmodule

[rtl/jgs_map.sv]
module jgs_map (
	input  jgs_pkg::cfg_t     cfg,
	input  jgs_pkg::poll_t    poll,
	input  logic [31:0]       count,
	output jgs_pkg::pad_rec_t rec
);
	import jgs_pkg::*;

	// An axis passes when v >= d or v <= -d; compare on 18 bits so every d fits.
	function automatic logic [15:0] deadzone(input logic [15:0] v, input logic [15:0] d);
		logic signed [17:0] vs;
		logic signed [17:0] ds;
		begin
			vs = {{2{v[15]}}, v};
			ds = {2'b00, d};
			deadzone = (vs >= ds || vs <= -ds) ? v : 16'd0;
		end
	endfunction

	logic [4:0]  ctl;
	logic        slot_ok;
	logic [15:0] btn_bits;
	logic [15:0] hat_bits;
	logic [15:0] hat;
	logic [15:0] z;
	logic [15:0] z_mag;
	logic [23:0] z_prod;
	logic [8:0]  q_est;
	logic [24:0] q_mul;
	logic [24:0] rem;
	logic [7:0]  tl_val;
	logic [7:0]  tr_val;
	logic [7:0]  trig_scaled;
	logic        trig_keep;
	logic [15:0] lx;
	logic [15:0] ly;
	logic [15:0] rx;
	logic [15:0] ry;

	// Slot selection; unknown slots have no controller.
	always_comb begin
		slot_ok = 1'b1;
		ctl     = 5'd0;
		priority if (poll.user_index == 8'd0 || poll.user_index == USER_ANY) begin
			ctl = cfg.slot0;
		end else if (poll.user_index == 8'd1) begin
			ctl = cfg.slot1;
		end else if (poll.user_index == 8'd2) begin
			ctl = cfg.slot2;
		end else if (poll.user_index == 8'd3) begin
			ctl = cfg.slot3;
		end else begin
			slot_ok = 1'b0;
		end
	end

	// Button remap to the standard pad bits.
	always_comb begin
		btn_bits = 16'd0;
		if (poll.raw_buttons[0]) btn_bits = btn_bits | PAD_A;
		if (poll.raw_buttons[1]) btn_bits = btn_bits | PAD_B;
		if (poll.raw_buttons[2]) btn_bits = btn_bits | PAD_X;
		if (poll.raw_buttons[3]) btn_bits = btn_bits | PAD_Y;
		if (poll.raw_buttons[4]) btn_bits = btn_bits | PAD_LSHLD;
		if (poll.raw_buttons[5]) btn_bits = btn_bits | PAD_RSHLD;
		if (poll.raw_buttons[6]) btn_bits = btn_bits | PAD_BACK;
		if (poll.raw_buttons[7]) btn_bits = btn_bits | PAD_START;
		if (poll.raw_buttons[8]) btn_bits = btn_bits | PAD_LTHUMB;
		if (poll.raw_buttons[9]) btn_bits = btn_bits | PAD_RTHUMB;
	end

	// Hat octants by range compare. The centred code lies past the last
	// octant, so it sets no bit on its own.
	assign hat = poll.hat_angle;
	always_comb begin
		hat_bits = 16'd0;
		if (hat < HAT_OCT2 || (hat >= HAT_OCT7 && hat < HAT_OCT8))
			hat_bits = hat_bits | PAD_UP;
		if (hat >= HAT_OCT1 && hat < HAT_OCT4)
			hat_bits = hat_bits | PAD_RIGHT;
		if (hat >= HAT_OCT3 && hat < HAT_OCT6)
			hat_bits = hat_bits | PAD_DOWN;
		if (hat >= HAT_OCT5 && hat < HAT_OCT8)
			hat_bits = hat_bits | PAD_LEFT;
	end

	// Trigger scaling. The product 255*|z| is divided by 32768 with a shift.
	// For the positive side the divisor is 32767: the shifted estimate is
	// at most one low, so one compare and an increment correct it.
	assign z      = poll.axis_trigger;
	assign z_mag  = z[15] ? (16'd0 - z) : z;
	assign z_prod = {z_mag, 8'd0} - {8'd0, z_mag};
	assign q_est  = {1'b0, z_prod[22:15]};
	assign q_mul  = {1'b0, z_prod} + 25'(q_est);
	assign rem    = q_mul - {1'b0, q_est, 15'd0};
	assign tl_val = (rem >= {9'd0, TRIG_RANGE_POS}) ? (q_est[7:0] + 8'd1) : q_est[7:0];
	assign tr_val = z_prod[22:15];
	assign trig_scaled = z[15] ? tr_val : tl_val;
	assign trig_keep   = (z != 16'd0) && (trig_scaled >= cfg.trig_thr);

	// Stick deadzones; the Y axes come out as -1 minus the value.
	assign lx = deadzone(poll.axis_left_x, cfg.left_dz);
	assign ly = deadzone(poll.axis_left_y, cfg.left_dz);
	assign rx = deadzone(poll.axis_right_x, cfg.right_dz);
	assign ry = deadzone(poll.axis_right_y, cfg.right_dz);

	// Assemble the record; a failed read leaves every other field zero.
	always_comb begin
		rec = '0;
		if (!slot_ok || ctl == 5'd0 || !cfg.present) begin
			rec.status = 1'b1;
		end else begin
			rec.status            = 1'b0;
			rec.target_controller = 4'(ctl - 5'd1);
			rec.pad_buttons       = btn_bits | hat_bits;
			rec.thumb_left_x      = lx;
			rec.thumb_left_y      = ~ly;
			rec.thumb_right_x     = rx;
			rec.thumb_right_y     = ~ry;
			rec.trigger_left      = (trig_keep && !z[15]) ? trig_scaled : 8'd0;
			rec.trigger_right     = (trig_keep && z[15]) ? trig_scaled : 8'd0;
			rec.packet_number     = count;
		end
	end

endmodule
